// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property holds at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition never occurs outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

// File: rtl/cigp_pkg.sv
// ----------------------------------------------------------------------------
// cigp_pkg
// Shared types and constants of the intrinsics to clip matrix block.
// ----------------------------------------------------------------------------
package cigp_pkg;
  localparam int NUM_W       = 72;   // dividend width, even for two bits a step
  localparam int DEN_W       = 31;
  localparam int DIV_STEPS   = NUM_W / 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int NJOBS       = 6;

  // division slots
  localparam int J_M0  = 0;
  localparam int J_M5  = 1;
  localparam int J_M8  = 2;
  localparam int J_M9  = 3;
  localparam int J_M10 = 4;
  localparam int J_M14 = 5;

  // register indexes
  localparam logic [1:0] REG_NEAR   = 2'd0;
  localparam logic [1:0] REG_FAR    = 2'd1;
  localparam logic [1:0] REG_INVERT = 2'd2;

  localparam logic [31:0] MINUS_ONE_Q24 = 32'hFF00_0000;

  typedef struct packed {
    logic             neg;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } job_t;

  typedef struct packed {
    job_t [NJOBS-1:0] jobs;
  } req_t;
endpackage

// File: rtl/camera_intrinsics_to_gl_projection_core.sv
// ----------------------------------------------------------------------------
// camera_intrinsics_to_gl_projection_core
// Camera intrinsics to OpenGL projection matrix, Q16.16 in, Q8.24 out.
// ----------------------------------------------------------------------------
// Usage:
//  in_*  : one request per camera setup; in_tuser is the valid flag, a
//          request with it clear is consumed and gives no output.
//  out_* : sixteen column-major elements per valid request, tuser holds
//          the element index, tlast marks the sixteenth.
//  cfg_* : near plane, far plane and invert flag; always ready.
// A request passes the product stage, the queue, six parallel dividers
//  (two quotient bits a cycle each), capture and the output register;
//  then one element a cycle while the receiver is ready.
//  The emit of one matrix overlaps the division of the next request.
// A queue of QUEUE_DEPTH requests sits between front and back.
// Reset empties the queue and pipeline and reloads the registers.
// When the receiver stalls, output holds, the dividers finish and wait,
// then the queue fills and in_tready drops.
// ----------------------------------------------------------------------------
module camera_intrinsics_to_gl_projection_core #(
  parameter int QUEUE_DEPTH = cigp_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  // fx, fy, cx, cy (31 each), orig_w, orig_h, out_w, out_h (13 each)
  input  logic [175:0] in_tdata,
  // params_valid
  input  logic         in_tuser,
  input  logic         in_tvalid,
  output logic         in_tready,
  // matrix_value
  output logic [31:0]  out_tdata,
  // element_index
  output logic [3:0]   out_tuser,
  output logic         out_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_data
);
  logic [30:0]    near_r, far_r;
  logic           inv_r;
  cigp_pkg::req_t q_data;
  logic           q_valid, q_pop;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= 31'd3277;
      far_r  <= 31'd655360;
      inv_r  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cigp_pkg::REG_NEAR:   near_r <= cfg_data;
        cigp_pkg::REG_FAR:    far_r  <= cfg_data;
        cigp_pkg::REG_INVERT: inv_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cigp_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .near_plane  (near_r),
    .far_plane   (far_r),
    .invert_flag (inv_r),
    .q_data      (q_data),
    .q_valid     (q_valid),
    .q_pop       (q_pop)
  );

  cigp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_data     (q_data),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );
endmodule

// File: rtl/cigp_front.sv
// ----------------------------------------------------------------------------
// cigp_front
// Accepts requests, forms products, drops invalid ones and queues the
// six division jobs for the back end.
// ----------------------------------------------------------------------------
module cigp_front #(
  parameter int QUEUE_DEPTH = cigp_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [175:0]    in_tdata,
  input  logic            in_tuser,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [30:0]     near_plane,
  input  logic [30:0]     far_plane,
  input  logic            invert_flag,
  output cigp_pkg::req_t  q_data,
  output logic            q_valid,
  input  logic            q_pop
);
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // product stage
  logic        s1_v_r;
  logic [43:0] fxw_r, fyh_r, cxw_r, cyh_r;
  logic [25:0] dw_r, dh_r;
  logic [61:0] fn_r;

  // queue
  cigp_pkg::req_t   q_mem [QUEUE_DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             push;
  logic             in_acc;
  cigp_pkg::req_t   req;

  // combinational job forming
  logic        flip, fge, lt_x, lt_y;
  logic [49:0] ax, ay;
  logic [52:0] bx, by, magx, magy;
  logic [31:0] sum_fn;
  logic [30:0] dfn;

  assign push      = s1_v_r && (cnt_r != CW'(QUEUE_DEPTH));
  assign in_tready = !s1_v_r || push;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= in_tuser;
    end else if (push) begin
      s1_v_r <= 1'b0;
    end
    if (in_acc) begin
      fxw_r <= 44'(in_tdata[30:0])   * 44'(in_tdata[162:150]);
      fyh_r <= 44'(in_tdata[61:31])  * 44'(in_tdata[175:163]);
      cxw_r <= 44'(in_tdata[92:62])  * 44'(in_tdata[162:150]);
      cyh_r <= 44'(in_tdata[123:93]) * 44'(in_tdata[175:163]);
      dw_r  <= 26'(in_tdata[136:124]) * 26'(in_tdata[162:150]);
      dh_r  <= 26'(in_tdata[149:137]) * 26'(in_tdata[175:163]);
      fn_r  <= 62'(far_plane) * 62'(near_plane);
    end
  end

  always_comb begin
    flip   = !invert_flag;
    fge    = far_plane >= near_plane;
    dfn    = fge ? (far_plane - near_plane) : (near_plane - far_plane);
    sum_fn = 32'(far_plane) + 32'(near_plane);
    ax     = {dw_r, 24'd0};
    ay     = {dh_r, 24'd0};
    bx     = {cxw_r, 9'd0};
    by     = {cyh_r, 9'd0};
    lt_x   = 53'(ax) < bx;
    lt_y   = 53'(ay) < by;
    magx   = lt_x ? (bx - 53'(ax)) : (53'(ax) - bx);
    magy   = lt_y ? (by - 53'(ay)) : (53'(ay) - by);

    req.jobs[cigp_pkg::J_M0].neg  = 1'b0;
    req.jobs[cigp_pkg::J_M0].num  = 72'({fxw_r, 9'd0});
    req.jobs[cigp_pkg::J_M0].den  = 31'(dw_r);
    req.jobs[cigp_pkg::J_M5].neg  = flip;
    req.jobs[cigp_pkg::J_M5].num  = 72'({fyh_r, 9'd0});
    req.jobs[cigp_pkg::J_M5].den  = 31'(dh_r);
    req.jobs[cigp_pkg::J_M8].neg  = lt_x;
    req.jobs[cigp_pkg::J_M8].num  = 72'(magx);
    req.jobs[cigp_pkg::J_M8].den  = 31'(dw_r);
    req.jobs[cigp_pkg::J_M9].neg  = lt_y != flip;
    req.jobs[cigp_pkg::J_M9].num  = 72'(magy);
    req.jobs[cigp_pkg::J_M9].den  = 31'(dh_r);
    req.jobs[cigp_pkg::J_M10].neg = fge;
    req.jobs[cigp_pkg::J_M10].num = 72'({sum_fn, 24'd0});
    req.jobs[cigp_pkg::J_M10].den = dfn;
    req.jobs[cigp_pkg::J_M14].neg = fge;
    req.jobs[cigp_pkg::J_M14].num = 72'({fn_r, 9'd0});
    req.jobs[cigp_pkg::J_M14].den = dfn;
  end

  // job queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (q_pop) rp_r <= (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + CW'(push) - CW'(q_pop);
    end
    if (push) q_mem[wp_r] <= req;
  end

  assign q_valid = cnt_r != '0;
  assign q_data  = q_mem[rp_r];

`include "assert_macros.svh"
  `ASSERT_NEVER(a_pop_empty, clk, rst_n, q_pop && !q_valid, "pop from empty queue")
  `ASSERT_CLK(a_cnt_range, clk, rst_n, cnt_r <= CW'(QUEUE_DEPTH), "queue count overrun")
endmodule

// File: rtl/cigp_div.sv
// ----------------------------------------------------------------------------
// cigp_div
// Restoring divider, two quotient bits a cycle, with rounding to nearest
// (ties away) and signed saturation to 32 bits.
// ----------------------------------------------------------------------------
module cigp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  cigp_pkg::job_t             job,
  output logic                       done,
  output logic [31:0]                value
);
  localparam int SW = $clog2(cigp_pkg::DIV_STEPS + 1);

  logic [cigp_pkg::NUM_W-1:0] q_r, q_nxt;
  logic [32:0]                rem_r, rem_nxt, r1, r2;
  logic [cigp_pkg::DEN_W-1:0] den_r;
  logic                       neg_r, zero_r;
  logic [SW-1:0]              cnt_r;
  logic                       b1, b2, big, rnd;
  logic [32:0]                qr;

  // two dependent subtract steps
  always_comb begin
    r1 = {rem_r[31:0], q_r[cigp_pkg::NUM_W-1]};
    b1 = r1 >= 33'(den_r);
    if (b1) r1 = r1 - 33'(den_r);
    r2 = {r1[31:0], q_r[cigp_pkg::NUM_W-2]};
    b2 = r2 >= 33'(den_r);
    if (b2) r2 = r2 - 33'(den_r);
    rem_nxt = r2;
    q_nxt   = {q_r[cigp_pkg::NUM_W-3:0], b1, b2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= SW'(cigp_pkg::DIV_STEPS);
    end else if (start) begin
      cnt_r <= '0;
    end else if (!done) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (start) begin
      q_r    <= job.num;
      rem_r  <= '0;
      den_r  <= job.den;
      neg_r  <= job.neg && (job.num != '0);
      zero_r <= job.den == '0;
    end else if (!done) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = cnt_r == SW'(cigp_pkg::DIV_STEPS);

  // round and saturate
  always_comb begin
    big = |q_r[cigp_pkg::NUM_W-1:32];
    rnd = {rem_r[31:0], 1'b0} >= 33'(den_r);
    qr  = 33'(q_r[31:0]) + 33'(rnd);
    if (zero_r) begin
      value = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (neg_r) begin
      value = (big || qr > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(33'd0 - qr);
    end else begin
      value = (big || qr > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : qr[31:0];
    end
  end
endmodule

// File: rtl/cigp_back.sv
// ----------------------------------------------------------------------------
// cigp_back
// Runs six dividers per request and streams the sixteen matrix elements
// through an output register.
// ----------------------------------------------------------------------------
module cigp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  cigp_pkg::req_t  q_data,
  input  logic            q_valid,
  output logic            q_pop,
  output logic [31:0]     out_tdata,
  output logic [3:0]      out_tuser,
  output logic            out_tlast,
  output logic            out_tvalid,
  input  logic            out_tready
);
  logic                       div_busy_r, emit_busy_r, out_v_r;
  logic [cigp_pkg::NJOBS-1:0] done;
  logic [31:0]                val [cigp_pkg::NJOBS];
  logic [31:0]                m_r [cigp_pkg::NJOBS];
  logic [3:0]                 idx_r;
  logic                       cap, adv;
  logic [31:0]                elem;
  logic [31:0]                data_r;
  logic [3:0]                 user_r;
  logic                       last_r;

  assign q_pop = q_valid && !div_busy_r;
  assign cap   = div_busy_r && (&done) && !emit_busy_r;
  assign adv   = emit_busy_r && (!out_v_r || out_tready);

  for (genvar g = 0; g < cigp_pkg::NJOBS; g++) begin : g_div
    cigp_div u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (q_pop),
      .job   (q_data.jobs[g]),
      .done  (done[g]),
      .value (val[g])
    );
  end

  // element select
  always_comb begin
    case (idx_r)
      4'd0:    elem = m_r[cigp_pkg::J_M0];
      4'd5:    elem = m_r[cigp_pkg::J_M5];
      4'd8:    elem = m_r[cigp_pkg::J_M8];
      4'd9:    elem = m_r[cigp_pkg::J_M9];
      4'd10:   elem = m_r[cigp_pkg::J_M10];
      4'd11:   elem = cigp_pkg::MINUS_ONE_Q24;
      4'd14:   elem = m_r[cigp_pkg::J_M14];
      default: elem = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r  <= 1'b0;
      emit_busy_r <= 1'b0;
      out_v_r     <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (q_pop) div_busy_r <= 1'b1;
      else if (cap) div_busy_r <= 1'b0;
      if (cap) begin
        emit_busy_r <= 1'b1;
        idx_r       <= '0;
      end else if (adv) begin
        idx_r <= idx_r + 1'b1;
        if (idx_r == 4'd15) emit_busy_r <= 1'b0;
      end
      if (adv) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
    if (cap) begin
      for (int i = 0; i < cigp_pkg::NJOBS; i++) m_r[i] <= val[i];
    end
    if (adv) begin
      data_r <= elem;
      user_r <= idx_r;
      last_r <= idx_r == 4'd15;
    end
  end

  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;
  assign out_tvalid = out_v_r;

`include "assert_macros.svh"
  `ASSERT_NEVER(a_cap_emit, clk, rst_n, cap && emit_busy_r, "capture while emitting")
  `ASSERT_NEVER(a_pop_busy, clk, rst_n, q_pop && div_busy_r, "start on busy dividers")
endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the intrinsics to clip matrix core against an in-bench predictor:
// directed corner requests, register sweeps and random camera setups, with
// random gaps on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;
  localparam logic [12:0] MAX13 = 13'h1FFF;

  typedef struct packed {
    logic [3:0]  idx;
    logic [31:0] val;
    logic        last;
  } elem_t;

  logic         clk;
  logic         rst_n;
  logic [175:0] in_tdata;
  logic         in_tuser;
  logic         in_tvalid;
  logic         in_tready;
  logic [31:0]  out_tdata;
  logic [3:0]   out_tuser;
  logic         out_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [30:0]  cfg_data;

  // predictor's copy of the registers
  logic [30:0] near_q, far_q;
  logic        inv_q;

  elem_t expected_elems[$];
  int    fail_count;
  int    idle_cycles;
  bit    no_stall;

  camera_intrinsics_to_gl_projection_core uut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report(input string msg);
    $display("MISMATCH: %s", msg);
    fail_count++;
  endtask

  // quotient rounded half away from zero, sign applied, saturated to int32
  function automatic logic [31:0] round_div(input bit neg_in, input logic [127:0] mag,
                                            input logic [127:0] den);
    logic [127:0] q, r;
    bit neg;
    neg = neg_in && (mag != 0);
    if (den == 0) return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    q = mag / den;
    r = mag % den;
    if (2 * r >= den) q = q + 1;
    if (neg) return (q > 128'h8000_0000) ? 32'h8000_0000 : 32'(-q);
    return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  function automatic logic [31:0] offset_term(input logic [127:0] c, input logic [127:0] o,
                                              input logic [127:0] s, input bit flip);
    logic [127:0] d, a, b;
    d = o * s;
    a = d << 24;
    b = (c * s) << 9;
    return (a < b) ? round_div(!flip, b - a, d) : round_div(flip, a - b, d);
  endfunction

  task automatic predict_matrix(input logic [175:0] d);
    logic [127:0] fx, fy, cx, cy, ow, oh, w, h, fr, nr, span;
    logic [31:0]  m [16];
    bit flip, fge;
    fx = 128'(d[30:0]);    fy = 128'(d[61:31]);
    cx = 128'(d[92:62]);   cy = 128'(d[123:93]);
    ow = 128'(d[136:124]); oh = 128'(d[149:137]);
    w  = 128'(d[162:150]); h  = 128'(d[175:163]);
    fr = 128'(far_q); nr = 128'(near_q);
    flip = !inv_q;
    fge = fr >= nr;
    span = fge ? fr - nr : nr - fr;
    foreach (m[k]) m[k] = '0;
    m[0]  = round_div(1'b0, (fx * w) << 9, ow * w);
    m[5]  = round_div(flip, (fy * h) << 9, oh * h);
    m[8]  = offset_term(cx, ow, w, 1'b0);
    m[9]  = offset_term(cy, oh, h, flip);
    m[10] = round_div(fge, (fr + nr) << 24, span);
    m[11] = cigp_pkg::MINUS_ONE_Q24;
    m[14] = round_div(fge, (fr * nr) << 9, span);
    for (int k = 0; k < 16; k++) expected_elems.push_back('{4'(k), m[k], k == 15});
  endtask

  // one request; gap drawn before it
  task automatic send_setup(input logic [175:0] d, input bit ok);
    int gap;
    gap = $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= d;
    in_tuser  <= ok;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (ok) predict_matrix(d);
    @(negedge clk);
  endtask

  function automatic logic [175:0] pack_setup(input logic [30:0] fx, fy, cx, cy,
                                              input logic [12:0] ow, oh, w, h);
    return {h, w, oh, ow, cy, cx, fy, fx};
  endfunction

  // waits until the matrices are drained and the dividers are quiet
  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_elems.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      cigp_pkg::REG_NEAR:   near_q = val;
      cigp_pkg::REG_FAR:    far_q  = val;
      cigp_pkg::REG_INVERT: inv_q  = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [30:0] rand31;
    case ($urandom_range(0, 3))
      0: return 31'($urandom_range(1, 1 << 20));
      1: return 31'($urandom);
      2: return 31'($urandom_range(1 << 16, 4000 << 16));
      default: return MAX31 - 31'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [12:0] rand13;
    return ($urandom_range(0, 5) == 0) ? 13'($urandom) : 13'($urandom_range(1, 4096));
  endfunction

  task automatic test_corners;
    send_setup(pack_setup(31'(600 << 16), 31'(600 << 16), 31'(320 << 16), 31'(240 << 16),
                          13'd640, 13'd480, 13'd640, 13'd480), 1'b1);
    send_setup(pack_setup(31'(600 << 16), 31'(600 << 16), 31'(320 << 16), 31'(240 << 16),
                          13'd640, 13'd480, 13'd1280, 13'd720), 1'b1);
    send_setup(pack_setup(MAX31, MAX31, MAX31, MAX31, 13'd1, 13'd1, MAX13, MAX13), 1'b1);
    send_setup(pack_setup(MAX31, MAX31, MAX31, MAX31, MAX13, MAX13, 13'd1, 13'd1), 1'b1);
    send_setup(pack_setup(31'd1, 31'd1, 31'd0, 31'd0, MAX13, MAX13, MAX13, MAX13), 1'b1);
    // degenerate focal lengths
    send_setup(pack_setup(31'd0, 31'd0, 31'(100 << 16), 31'(100 << 16),
                          13'd200, 13'd200, 13'd200, 13'd200), 1'b1);
    // zero sizes make the divisors zero
    send_setup(pack_setup(31'(500 << 16), 31'(500 << 16), 31'(10 << 16), 31'(10 << 16),
                          13'd0, 13'd0, 13'd640, 13'd480), 1'b1);
    send_setup(pack_setup(31'(500 << 16), 31'(500 << 16), 31'd0, 31'd0,
                          13'd640, 13'd480, 13'd0, 13'd0), 1'b1);
    send_setup(pack_setup(31'd0, 31'd0, 31'd0, 31'd0, 13'd0, 13'd0, 13'd0, 13'd0), 1'b1);
    // invalid parameters give nothing, then all ones as a valid request
    send_setup(pack_setup(31'(600 << 16), 31'(600 << 16), 31'(320 << 16), 31'(240 << 16),
                          13'd640, 13'd480, 13'd640, 13'd480), 1'b0);
    send_setup({176{1'b1}}, 1'b0);
    send_setup({176{1'b1}}, 1'b1);
  endtask

  task automatic test_planes;
    write_reg(cigp_pkg::REG_INVERT, 31'd1);
    test_corners();
    write_reg(cigp_pkg::REG_NEAR, 31'd1);
    write_reg(cigp_pkg::REG_FAR, MAX31);
    send_setup(pack_setup(31'(800 << 16), 31'(700 << 16), 31'(300 << 16), 31'(200 << 16),
                          13'd640, 13'd480, 13'd320, 13'd240), 1'b1);
    // far below near
    write_reg(cigp_pkg::REG_NEAR, MAX31);
    write_reg(cigp_pkg::REG_FAR, 31'd1);
    write_reg(cigp_pkg::REG_INVERT, 31'd0);
    send_setup(pack_setup(31'(800 << 16), 31'(700 << 16), 31'(300 << 16), 31'(200 << 16),
                          13'd640, 13'd480, 13'd320, 13'd240), 1'b1);
    // far equal to near
    write_reg(cigp_pkg::REG_FAR, MAX31);
    send_setup(pack_setup(31'(800 << 16), 31'(700 << 16), 31'(300 << 16), 31'(200 << 16),
                          13'd640, 13'd480, 13'd320, 13'd240), 1'b1);
    write_reg(cigp_pkg::REG_NEAR, 31'd1000);
    write_reg(cigp_pkg::REG_FAR, 31'd1000);
    send_setup(pack_setup(31'd1, 31'd2, 31'd3, 31'd4, 13'd5, 13'd6, 13'd7, 13'd8), 1'b1);
  endtask

  task automatic test_random;
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(cigp_pkg::REG_NEAR, ($urandom_range(0, 3) == 0) ? rand31() :
                31'($urandom_range(1, 1 << 17)));
      write_reg(cigp_pkg::REG_FAR, ($urandom_range(0, 3) == 0) ? rand31() :
                31'($urandom_range(1 << 17, 1 << 26)));
      write_reg(cigp_pkg::REG_INVERT, 31'($urandom_range(0, 1)));
      no_stall = (phase % 3 == 2);
      for (int i = 0; i < 37; i++)
        send_setup(pack_setup(rand31(), rand31(), rand31(), rand31(),
                              rand13(), rand13(), rand13(), rand13()),
                   $urandom_range(0, 7) != 0);
    end
    no_stall = 1'b0;
  endtask

  // receiver: random stalls per element, unless no_stall is set
  initial begin
    int wait_cycles;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (no_stall) out_tready <= 1'b1;
      else begin
        wait_cycles = $urandom_range(0, 10);
        if (wait_cycles > 0) begin
          out_tready <= 1'b0;
          repeat (wait_cycles) @(negedge clk);
        end
        out_tready <= 1'b1;
        @(posedge clk);
        while (!out_tvalid) @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    elem_t exp_e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_elems.size() == 0) report("element with no matrix pending");
      else begin
        exp_e = expected_elems.pop_front();
        if (out_tuser !== exp_e.idx)
          report($sformatf("index got %0d want %0d", out_tuser, exp_e.idx));
        if (out_tdata !== exp_e.val)
          report($sformatf("element %0d got %h want %h", exp_e.idx, out_tdata, exp_e.val));
        if (out_tlast !== exp_e.last)
          report($sformatf("element %0d last got %b", exp_e.idx, out_tlast));
      end
    end
  end

  // watchdog on cycles without any handshake on input, output or config
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0; in_tdata = '0; in_tuser = 1'b0; in_tvalid = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    fail_count = 0; idle_cycles = 0; no_stall = 1'b0;
    near_q = 31'd3277; far_q = 31'd655360; inv_q = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    test_corners();
    test_planes();
    test_random();
    drain();
    if (expected_elems.size() != 0) report("matrices left over");
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl
rtl/cigp_pkg.sv
rtl/cigp_front.sv
rtl/cigp_div.sv
rtl/cigp_back.sv
rtl/camera_intrinsics_to_gl_projection_core.sv
dv/tb.sv
